### src/gbsp_pkg.sv
// gbsp_pkg: types, constants and codes shared by the grid search block
// no dependencies; used by grid_bfs_shortest_path_unit through scoped names

package gbsp_pkg;

  // grid limits
  localparam int unsigned ROWS_MAX  = 64;
  localparam int unsigned COLS_MAX  = 64;
  localparam int unsigned CELLS_MAX = ROWS_MAX * COLS_MAX;

  // derived widths
  localparam int unsigned ROW_W  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int unsigned COL_W  = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int unsigned RSZ_W  = ROW_W + 1;
  localparam int unsigned CSZ_W  = COL_W + 1;
  localparam int unsigned ADDR_W = (CELLS_MAX > 1) ? $clog2(CELLS_MAX) : 1;
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned PROD_W = ROW_W + CSZ_W + 1;

  // fixed field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned CFG_SIZE_W = 7;
  localparam int unsigned CFG_POS_W  = 6;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CMP_W      = ((RSZ_W > CFG_SIZE_W) ? RSZ_W : CFG_SIZE_W) + 1;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // cell kinds; a visited open cell is rewritten as a wall
  localparam logic [KIND_W-1:0] KIND_OPEN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROWS      = 2'd0,
    REG_COLS      = 2'd1,
    REG_START_ROW = 2'd2,
    REG_START_COL = 2'd3
  } cfg_reg_e;

  // neighbor order: right, left, down, up, then none left
  typedef enum logic [2:0] {
    DIR_RIGHT = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DONE  = 3'd4
  } dir_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SCHK,
    ST_POP,
    ST_CUR,
    ST_SCAN,
    ST_DONE
  } state_e;

  // frontier queue entry: distance and cell position
  typedef struct packed {
    logic [LEN_W-1:0] steps;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } qent_t;

endpackage

### src/grid_bfs_shortest_path_unit.sv
// grid_bfs_shortest_path_unit: loads a grid maze and runs a breadth-first search
// depends on gbsp_pkg (types, widths, codes)
//
// channel   | signals                          | direction | contents
// ----------+----------------------------------+-----------+-------------------------------
// s_axis    | s_axis_tvalid/tready/tdata/tlast | in        | one grid cell, tlast = last cell
// m_axis    | m_axis_tvalid/tready/tdata       | out       | found flag and path length
// cfg       | cfg_we_i, cfg_addr_i, cfg_wdata_i| in        | grid size and start position
//
// cells load at one per cycle while the block is loading; after the last cell the
// search runs, per dequeued cell, a queue read, a setup step and a two-stage
// neighbor lookup through the cell memory with its one read and one write port.
// no cell is accepted during the search.
// a finished result waits in an output register; loading of the next grid
// proceeds while it waits. reset clears control state and config registers only, no memory sweep.

module grid_bfs_shortest_path_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [gbsp_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [gbsp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // cell input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [gbsp_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [1:0] cell_kind, rest zero
  input  logic                               s_axis_tlast,   // last_cell
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [gbsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata    // [0] found, [12:1] path_length
);

  localparam int unsigned ROW_W  = gbsp_pkg::ROW_W;
  localparam int unsigned COL_W  = gbsp_pkg::COL_W;
  localparam int unsigned RSZ_W  = gbsp_pkg::RSZ_W;
  localparam int unsigned CSZ_W  = gbsp_pkg::CSZ_W;
  localparam int unsigned ADDR_W = gbsp_pkg::ADDR_W;
  localparam int unsigned CNT_W  = gbsp_pkg::CNT_W;
  localparam int unsigned PROD_W = gbsp_pkg::PROD_W;
  localparam int unsigned CMP_W  = gbsp_pkg::CMP_W;
  localparam int unsigned KIND_W = gbsp_pkg::KIND_W;
  localparam int unsigned LEN_W  = gbsp_pkg::LEN_W;

  // linear cell index r * cols + c
  function automatic logic [ADDR_W-1:0] lin_idx(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c,
                                                input logic [CSZ_W-1:0] n);
    logic [PROD_W-1:0] p;
    p = PROD_W'(r) * PROD_W'(n) + PROD_W'(c);
    return p[ADDR_W-1:0];
  endfunction

  // config registers
  logic [gbsp_pkg::CFG_SIZE_W-1:0] rows_q, cols_q;
  logic [gbsp_pkg::CFG_POS_W-1:0]  srow_q, scol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gbsp_pkg::CFG_SIZE_W'(64);
      cols_q <= gbsp_pkg::CFG_SIZE_W'(64);
      srow_q <= '0;
      scol_q <= '0;
    end else if (cfg_we_i) begin
      unique case (gbsp_pkg::cfg_reg_e'(cfg_addr_i))
        gbsp_pkg::REG_ROWS:      rows_q <= cfg_wdata_i[gbsp_pkg::CFG_SIZE_W-1:0];
        gbsp_pkg::REG_COLS:      cols_q <= cfg_wdata_i[gbsp_pkg::CFG_SIZE_W-1:0];
        gbsp_pkg::REG_START_ROW: srow_q <= cfg_wdata_i[gbsp_pkg::CFG_POS_W-1:0];
        gbsp_pkg::REG_START_COL: scol_q <= cfg_wdata_i[gbsp_pkg::CFG_POS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped grid size: zero acts as one, above the maximum acts as the maximum
  logic [RSZ_W-1:0] rows_eff;
  logic [CSZ_W-1:0] cols_eff;

  always_comb begin
    if (rows_q == '0) begin
      rows_eff = RSZ_W'(1);
    end else if (CMP_W'(rows_q) > CMP_W'(gbsp_pkg::ROWS_MAX)) begin
      rows_eff = RSZ_W'(gbsp_pkg::ROWS_MAX);
    end else begin
      rows_eff = RSZ_W'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = CSZ_W'(1);
    end else if (CMP_W'(cols_q) > CMP_W'(gbsp_pkg::COLS_MAX)) begin
      cols_eff = CSZ_W'(gbsp_pkg::COLS_MAX);
    end else begin
      cols_eff = CSZ_W'(cols_q);
    end
  end

  // start position checks
  logic             start_out;
  logic [ROW_W-1:0] start_r;
  logic [COL_W-1:0] start_c;
  logic [ADDR_W-1:0] start_k;

  assign start_out = (CMP_W'(srow_q) >= CMP_W'(rows_eff)) ||
                     (CMP_W'(scol_q) >= CMP_W'(cols_eff));
  assign start_r   = ROW_W'(srow_q);
  assign start_c   = COL_W'(scol_q);
  assign start_k   = lin_idx(start_r, start_c, cols_eff);

  // sequencer and datapath registers
  gbsp_pkg::state_e state_q, state_d;
  gbsp_pkg::dir_e   dir_q, dir_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] tail_q, tail_d;
  logic [ROW_W-1:0] cur_r_q, cur_r_d;
  logic [COL_W-1:0] cur_c_q, cur_c_d;
  logic [LEN_W-1:0] nd_q, nd_d;
  logic             chk_vld_q, chk_vld_d;
  logic             chk_ld_q, chk_ld_d;
  logic [ADDR_W-1:0] chk_k_q, chk_k_d;
  logic [ROW_W-1:0] chk_r_q, chk_r_d;
  logic [COL_W-1:0] chk_c_q, chk_c_d;
  logic             res_found_q, res_found_d;
  logic [LEN_W-1:0] res_len_q, res_len_d;
  logic             m_valid_q, m_valid_d;
  logic [gbsp_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  // memories
  logic [KIND_W-1:0]   cell_mem [gbsp_pkg::CELLS_MAX];
  gbsp_pkg::qent_t     q_mem    [gbsp_pkg::CELLS_MAX];
  logic [KIND_W-1:0]   cell_rd_q;
  gbsp_pkg::qent_t     q_rd_q;
  logic                cell_we;
  logic [ADDR_W-1:0]   cell_waddr, cell_raddr;
  logic [KIND_W-1:0]   cell_wdata;
  logic                q_we;
  logic [ADDR_W-1:0]   q_waddr;
  gbsp_pkg::qent_t     q_wdata;

  // input side
  logic              s_acc;
  logic              load_room;
  logic [KIND_W-1:0] in_kind;

  assign s_axis_tready = (state_q == gbsp_pkg::ST_LOAD);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign load_room     = (load_cnt_q < CNT_W'(gbsp_pkg::CELLS_MAX));
  assign in_kind       = (s_axis_tdata[KIND_W-1:0] == gbsp_pkg::KIND_BAD) ?
                         gbsp_pkg::KIND_WALL : s_axis_tdata[KIND_W-1:0];

  // output side
  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // neighbor issue stage
  logic             nb_in;
  logic [ROW_W-1:0] nb_r;
  logic [COL_W-1:0] nb_c;
  logic [ADDR_W-1:0] nb_k;
  logic [RSZ_W-1:0] r_inc;
  logic [CSZ_W-1:0] c_inc;

  assign r_inc = RSZ_W'(cur_r_q) + RSZ_W'(1);
  assign c_inc = CSZ_W'(cur_c_q) + CSZ_W'(1);

  always_comb begin
    nb_r  = cur_r_q;
    nb_c  = cur_c_q;
    nb_in = 1'b0;
    unique case (dir_q)
      gbsp_pkg::DIR_RIGHT: begin
        nb_c  = c_inc[COL_W-1:0];
        nb_in = (c_inc < cols_eff);
      end
      gbsp_pkg::DIR_LEFT: begin
        nb_c  = cur_c_q - COL_W'(1);
        nb_in = (cur_c_q != '0);
      end
      gbsp_pkg::DIR_DOWN: begin
        nb_r  = r_inc[ROW_W-1:0];
        nb_in = (r_inc < rows_eff);
      end
      gbsp_pkg::DIR_UP: begin
        nb_r  = cur_r_q - ROW_W'(1);
        nb_in = (cur_r_q != '0);
      end
      default: nb_in = 1'b0;
    endcase
  end

  assign nb_k = lin_idx(nb_r, nb_c, cols_eff);

  // check stage: kind of the looked-up cell, unloaded cells are walls
  logic [KIND_W-1:0] chk_kind;
  logic              chk_hit, chk_open, q_room;

  assign chk_kind = chk_ld_q ? cell_rd_q : gbsp_pkg::KIND_WALL;
  assign chk_hit  = chk_vld_q && (chk_kind == gbsp_pkg::KIND_TARGET);
  assign chk_open = chk_vld_q && (chk_kind == gbsp_pkg::KIND_OPEN);
  assign q_room   = (tail_q < CNT_W'(gbsp_pkg::CELLS_MAX));

  logic q_empty;
  assign q_empty = (head_q == tail_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbsp_pkg::ST_LOAD:  if (s_acc && s_axis_tlast) state_d = gbsp_pkg::ST_START;
      gbsp_pkg::ST_START: state_d = start_out ? gbsp_pkg::ST_DONE : gbsp_pkg::ST_SCHK;
      gbsp_pkg::ST_SCHK:  state_d = (chk_kind == gbsp_pkg::KIND_TARGET) ?
                                    gbsp_pkg::ST_DONE : gbsp_pkg::ST_POP;
      gbsp_pkg::ST_POP:   state_d = q_empty ? gbsp_pkg::ST_DONE : gbsp_pkg::ST_CUR;
      gbsp_pkg::ST_CUR:   state_d = gbsp_pkg::ST_SCAN;
      gbsp_pkg::ST_SCAN: begin
        if (chk_hit) begin
          state_d = gbsp_pkg::ST_DONE;
        end else if (dir_q == gbsp_pkg::DIR_DONE) begin
          state_d = gbsp_pkg::ST_POP;
        end
      end
      gbsp_pkg::ST_DONE:  if (out_free) state_d = gbsp_pkg::ST_LOAD;
      default:            state_d = gbsp_pkg::ST_LOAD;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    dir_d       = dir_q;
    load_cnt_d  = load_cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_r_d     = cur_r_q;
    cur_c_d     = cur_c_q;
    nd_d        = nd_q;
    chk_vld_d   = 1'b0;
    chk_ld_d    = chk_ld_q;
    chk_k_d     = chk_k_q;
    chk_r_d     = chk_r_q;
    chk_c_d     = chk_c_q;
    res_found_d = res_found_q;
    res_len_d   = res_len_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    cell_we     = 1'b0;
    cell_waddr  = chk_k_q;
    cell_wdata  = gbsp_pkg::KIND_WALL;
    cell_raddr  = nb_k;
    q_we        = 1'b0;
    q_waddr     = tail_q[ADDR_W-1:0];
    q_wdata     = '{steps: nd_q, row: chk_r_q, col: chk_c_q};

    unique case (state_q)
      // store cells in row-major order, drop the overflow
      gbsp_pkg::ST_LOAD: begin
        if (s_acc && load_room) begin
          cell_we    = 1'b1;
          cell_waddr = load_cnt_q[ADDR_W-1:0];
          cell_wdata = in_kind;
          load_cnt_d = load_cnt_q + CNT_W'(1);
        end
      end
      // look up the start cell
      gbsp_pkg::ST_START: begin
        cell_raddr  = start_k;
        chk_k_d     = start_k;
        chk_r_d     = start_r;
        chk_c_d     = start_c;
        chk_ld_d    = (CNT_W'(start_k) < load_cnt_q);
        res_found_d = 1'b0;
        res_len_d   = '0;
      end
      // start is a target, or seed the queue with it
      gbsp_pkg::ST_SCHK: begin
        if (chk_kind == gbsp_pkg::KIND_TARGET) begin
          res_found_d = 1'b1;
          res_len_d   = '0;
        end else begin
          cell_we = 1'b1;
          q_we    = 1'b1;
          q_waddr = '0;
          q_wdata = '{steps: '0, row: chk_r_q, col: chk_c_q};
          head_d  = '0;
          tail_d  = CNT_W'(1);
        end
      end
      // dequeue the next cell
      gbsp_pkg::ST_POP: begin
        if (!q_empty) begin
          head_d = head_q + CNT_W'(1);
        end
      end
      // unpack the dequeued cell
      gbsp_pkg::ST_CUR: begin
        cur_r_d = q_rd_q.row;
        cur_c_d = q_rd_q.col;
        nd_d    = (q_rd_q.steps == gbsp_pkg::LEN_MAX) ?
                  gbsp_pkg::LEN_MAX : q_rd_q.steps + LEN_W'(1);
        dir_d   = gbsp_pkg::DIR_RIGHT;
      end
      // issue one neighbor a cycle, check the one issued before
      gbsp_pkg::ST_SCAN: begin
        if (dir_q != gbsp_pkg::DIR_DONE) begin
          chk_vld_d = nb_in;
          chk_k_d   = nb_k;
          chk_r_d   = nb_r;
          chk_c_d   = nb_c;
          chk_ld_d  = (CNT_W'(nb_k) < load_cnt_q);
          dir_d     = gbsp_pkg::dir_e'(dir_q + 3'd1);
        end
        if (chk_hit) begin
          res_found_d = 1'b1;
          res_len_d   = nd_q;
        end else if (chk_open && q_room) begin
          cell_we = 1'b1;
          q_we    = 1'b1;
          tail_d  = tail_q + CNT_W'(1);
        end
      end
      // hand the result to the output register
      gbsp_pkg::ST_DONE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_data_d   = gbsp_pkg::OUT_DATA_W'({res_len_q, res_found_q});
          load_cnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gbsp_pkg::ST_LOAD;
      dir_q      <= gbsp_pkg::DIR_DONE;
      load_cnt_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      chk_vld_q  <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      dir_q      <= dir_d;
      load_cnt_q <= load_cnt_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      chk_vld_q  <= chk_vld_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_r_q     <= cur_r_d;
    cur_c_q     <= cur_c_d;
    nd_q        <= nd_d;
    chk_ld_q    <= chk_ld_d;
    chk_k_q     <= chk_k_d;
    chk_r_q     <= chk_r_d;
    chk_c_q     <= chk_c_d;
    res_found_q <= res_found_d;
    res_len_q   <= res_len_d;
    m_data_q    <= m_data_d;
  end

  // cell memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rd_q <= cell_mem[cell_raddr];
  end

  // frontier queue memory, read at the head
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd_q <= q_mem[head_q[ADDR_W-1:0]];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### tb/grid_bfs_shortest_path_unit_tb.sv
// grid_bfs_shortest_path_unit_tb: self-checking bench for the grid maze search block
// streams mazes cell by cell, predicts found flag and path length with its own search
// depends on gbsp_pkg and grid_bfs_shortest_path_unit
`timescale 1ns / 100ps

module grid_bfs_shortest_path_unit_tb;

  localparam int unsigned LEN_W      = gbsp_pkg::LEN_W;
  localparam int unsigned KIND_W     = gbsp_pkg::KIND_W;
  localparam int unsigned CELLS_MAX  = gbsp_pkg::CELLS_MAX;
  localparam int unsigned ROWS_MAX   = gbsp_pkg::ROWS_MAX;
  localparam int unsigned COLS_MAX   = gbsp_pkg::COLS_MAX;
  localparam int unsigned CFG_SIZE_W = gbsp_pkg::CFG_SIZE_W;
  localparam int unsigned CFG_POS_W  = gbsp_pkg::CFG_POS_W;
  localparam int unsigned CFG_ADDR_W = gbsp_pkg::CFG_ADDR_W;
  localparam int unsigned CFG_DATA_W = gbsp_pkg::CFG_DATA_W;
  localparam int unsigned IN_DATA_W  = gbsp_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = gbsp_pkg::OUT_DATA_W;

  localparam int RANDOM_ITEMS  = 1800;
  localparam int QUIET_CYCLES  = 8;
  localparam int TAIL_CYCLES   = 50;
  localparam int ERROR_PRINTS  = 40;
  localparam int STEP_DR [4]   = '{0, 0, 1, -1};
  localparam int STEP_DC [4]   = '{1, -1, 0, 0};

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] len;
  } route_t;

  // search predictor and store of routes still owed by the block
  class shortest_path_board;
    logic [KIND_W-1:0]     cell_kinds [CELLS_MAX];
    bit                    visited [CELLS_MAX];
    int                    steps [CELLS_MAX];
    int                    frontier [CELLS_MAX];
    int                    cells_loaded;
    logic [CFG_SIZE_W-1:0] rows_cfg;
    logic [CFG_SIZE_W-1:0] cols_cfg;
    logic [CFG_POS_W-1:0]  srow_cfg;
    logic [CFG_POS_W-1:0]  scol_cfg;
    route_t                routes_due [$];
    int                    errors;

    function new();
      rows_cfg     = CFG_SIZE_W'(ROWS_MAX);
      cols_cfg     = CFG_SIZE_W'(COLS_MAX);
      srow_cfg     = '0;
      scol_cfg     = '0;
      cells_loaded = 0;
      errors       = 0;
    endfunction

    // zero acts as one, anything above the limit acts as the limit
    function int size_in_use(int v, int max_v);
      if (v == 0) return 1;
      return (v > max_v) ? max_v : v;
    endfunction

    function void note_reg(gbsp_pkg::cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        gbsp_pkg::REG_ROWS:      rows_cfg = val[CFG_SIZE_W-1:0];
        gbsp_pkg::REG_COLS:      cols_cfg = val[CFG_SIZE_W-1:0];
        gbsp_pkg::REG_START_ROW: srow_cfg = val[CFG_POS_W-1:0];
        gbsp_pkg::REG_START_COL: scol_cfg = val[CFG_POS_W-1:0];
        default: ;
      endcase
    endfunction

    // cells not loaded for this grid read as walls
    function logic [KIND_W-1:0] kind_of(int k);
      if (k >= cells_loaded) return gbsp_pkg::KIND_WALL;
      return cell_kinds[k];
    endfunction

    // breadth-first search, stops at the first target reached
    function route_t shortest_route();
      route_t r;
      int rows, cols, s, head, tail, cur, cr, ccol, rr, cc, k, nd;
      r    = '0;
      rows = size_in_use(int'(rows_cfg), ROWS_MAX);
      cols = size_in_use(int'(cols_cfg), COLS_MAX);
      if (int'(srow_cfg) >= rows || int'(scol_cfg) >= cols) return r;
      s = int'(srow_cfg) * cols + int'(scol_cfg);
      if (kind_of(s) == gbsp_pkg::KIND_TARGET) begin
        r.found = 1'b1;
        return r;
      end
      foreach (visited[i]) visited[i] = 1'b0;
      head        = 0;
      tail        = 1;
      visited[s]  = 1'b1;
      steps[s]    = 0;
      frontier[0] = s;
      while (head < tail) begin
        cur  = frontier[head];
        head = head + 1;
        cr   = cur / cols;
        ccol = cur % cols;
        nd   = (steps[cur] >= int'(gbsp_pkg::LEN_MAX)) ? int'(gbsp_pkg::LEN_MAX) :
               steps[cur] + 1;
        for (int i = 0; i < 4; i++) begin
          rr = cr + STEP_DR[i];
          cc = ccol + STEP_DC[i];
          if (rr < 0 || cc < 0 || rr >= rows || cc >= cols) continue;
          k = rr * cols + cc;
          if (kind_of(k) == gbsp_pkg::KIND_TARGET) begin
            r.found = 1'b1;
            r.len   = LEN_W'(nd);
            return r;
          end
          if (kind_of(k) == gbsp_pkg::KIND_OPEN && !visited[k] && tail < CELLS_MAX) begin
            visited[k]     = 1'b1;
            steps[k]       = nd;
            frontier[tail] = k;
            tail           = tail + 1;
          end
        end
      end
      return r;
    endfunction

    // accepted cell: code 3 is kept as a wall, cells past the store are dropped
    function void note_cell(logic [KIND_W-1:0] kind, bit last);
      logic [KIND_W-1:0] kept;
      kept = (kind == gbsp_pkg::KIND_BAD) ? gbsp_pkg::KIND_WALL : kind;
      if (cells_loaded < CELLS_MAX) begin
        cell_kinds[cells_loaded] = kept;
        cells_loaded             = cells_loaded + 1;
      end
      if (last) begin
        routes_due.push_back(shortest_route());
        cells_loaded = 0;
      end
    endfunction

    // accepted result against the oldest route owed
    function void check_result(logic [OUT_DATA_W-1:0] data);
      route_t want;
      route_t got;
      got = {data[0], data[LEN_W:1]};
      if (routes_due.size() == 0) begin
        errors = errors + 1;
        if (errors <= ERROR_PRINTS)
          $display("%0t: result with none owed, found %0d len %0d", $time, got.found, got.len);
        return;
      end
      want = routes_due.pop_front();
      if (got.found !== want.found) begin
        errors = errors + 1;
        if (errors <= ERROR_PRINTS)
          $display("%0t: found mismatch, expected %0d, actual %0d",
                   $time, want.found, got.found);
      end
      if (got.len !== want.len) begin
        errors = errors + 1;
        if (errors <= ERROR_PRINTS)
          $display("%0t: path_length mismatch, expected %0d, actual %0d",
                   $time, want.len, got.len);
      end
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  shortest_path_board paths = new();
  bit                 idle_on = 1'b1;
  logic [KIND_W-1:0]  maze [$];

  grid_bfs_shortest_path_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: check each transfer, stall in short bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) paths.check_result(m_axis_tdata);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one cell transfer, with an occasional gap before it
  task automatic send_cell(logic [KIND_W-1:0] kind, bit last);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_DATA_W'($urandom_range(0, 3));
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(kind);
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    paths.note_cell(kind, last);
  endtask

  task automatic send_grid();
    for (int i = 0; i < maze.size(); i++) send_cell(maze[i], i == maze.size() - 1);
  endtask

  // hold the sender until every owed route has come back
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (paths.routes_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_reg(gbsp_pkg::cfg_reg_e idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    paths.note_reg(idx, CFG_DATA_W'(val));
  endtask

  task automatic set_grid(int rows, int cols, int srow, int scol);
    program_reg(gbsp_pkg::REG_ROWS, rows);
    program_reg(gbsp_pkg::REG_COLS, cols);
    program_reg(gbsp_pkg::REG_START_ROW, srow);
    program_reg(gbsp_pkg::REG_START_COL, scol);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_case(int rows, int cols, int srow, int scol);
    wait_quiet();
    set_grid(rows, cols, srow, scol);
    send_grid();
  endtask

  // mostly small sizes, now and then a clamped or full-width one
  function automatic int pick_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
    if (sel == 1) return 64;
    if (sel <= 4) return $urandom_range(1, 24);
    return $urandom_range(1, 8);
  endfunction

  initial begin
    int rand_items, rows_v, cols_v, er, ec, sr, sc, total, n, t_pct, p, mode;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // start cell is a target, reset sizes and start
    maze = '{gbsp_pkg::KIND_TARGET};
    send_grid();
    // code 3 blocks the only way through
    maze = '{gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_BAD, gbsp_pkg::KIND_TARGET,
             gbsp_pkg::KIND_OPEN};
    run_case(1, 4, 0, 0);
    // small open maze, start in the far corner
    maze = '{gbsp_pkg::KIND_TARGET, gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_OPEN,
             gbsp_pkg::KIND_WALL, gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_OPEN};
    run_case(2, 3, 1, 2);
    // short grid, unloaded cells act as walls
    maze = '{gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_OPEN,
             gbsp_pkg::KIND_OPEN};
    run_case(3, 3, 0, 0);
    // zero sizes act as one, extra cell stored but unused
    maze = '{gbsp_pkg::KIND_TARGET};
    run_case(0, 0, 0, 0);
    maze = '{gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_TARGET};
    run_case(0, 0, 0, 0);
    // start outside the grid
    maze = '{gbsp_pkg::KIND_TARGET, gbsp_pkg::KIND_TARGET, gbsp_pkg::KIND_TARGET,
             gbsp_pkg::KIND_TARGET};
    run_case(2, 2, 2, 0);
    run_case(2, 2, 0, 63);
    // search starts from a wall or a code 3 cell
    maze = '{gbsp_pkg::KIND_WALL, gbsp_pkg::KIND_TARGET};
    run_case(1, 2, 0, 0);
    maze = '{gbsp_pkg::KIND_BAD, gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_TARGET};
    run_case(1, 3, 0, 0);
    // cells past the grid in use never read
    maze = '{gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_OPEN,
             gbsp_pkg::KIND_OPEN, gbsp_pkg::KIND_TARGET, gbsp_pkg::KIND_TARGET};
    run_case(2, 2, 0, 0);
    // one full row and one full column
    maze.delete();
    maze.push_back(gbsp_pkg::KIND_TARGET);
    repeat (COLS_MAX - 1) maze.push_back(gbsp_pkg::KIND_OPEN);
    run_case(1, 64, 0, 63);
    run_case(64, 1, 63, 0);
    // oversize settings clamp, cells past the store are dropped
    maze.delete();
    repeat (CELLS_MAX + 4) maze.push_back(gbsp_pkg::KIND_OPEN);
    maze[0] = gbsp_pkg::KIND_TARGET;
    run_case(127, 127, 63, 63);
    // serpentine maze for a long path
    maze.delete();
    for (int r = 0; r < ROWS_MAX; r++) begin
      for (int c = 0; c < COLS_MAX; c++) begin
        if (r % 2 == 0) maze.push_back(gbsp_pkg::KIND_OPEN);
        else if ((r % 4 == 1 && c == COLS_MAX - 1) || (r % 4 == 3 && c == 0))
          maze.push_back(gbsp_pkg::KIND_OPEN);
        else maze.push_back(gbsp_pkg::KIND_WALL);
      end
    end
    maze[(ROWS_MAX - 2) * COLS_MAX] = gbsp_pkg::KIND_TARGET;
    run_case(64, 64, 0, 0);

    // random mazes, settings changed between some of them
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items > RANDOM_ITEMS * 5 / 6) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 4) != 0);
      if (rand_items == 0 || $urandom_range(0, 2) == 0) begin
        rows_v = pick_size();
        cols_v = pick_size();
        er     = paths.size_in_use(rows_v, ROWS_MAX);
        ec     = paths.size_in_use(cols_v, COLS_MAX);
        sr     = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, er - 1);
        sc     = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, ec - 1);
        wait_quiet();
        set_grid(rows_v, cols_v, sr, sc);
      end
      total = er * ec;
      mode  = $urandom_range(0, 9);
      if (total > 600) n = $urandom_range(1, 60);
      else if (mode == 8) n = $urandom_range(1, total);
      else if (mode == 9) n = total + $urandom_range(1, 5);
      else n = total;
      case ($urandom_range(0, 2))
        0: t_pct = 0;
        1: t_pct = 3;
        default: t_pct = 12;
      endcase
      maze.delete();
      repeat (n) begin
        p = $urandom_range(0, 99);
        if (p < t_pct) maze.push_back(gbsp_pkg::KIND_TARGET);
        else if (p < t_pct + 3) maze.push_back(gbsp_pkg::KIND_BAD);
        else if (p < t_pct + 30) maze.push_back(gbsp_pkg::KIND_WALL);
        else maze.push_back(gbsp_pkg::KIND_OPEN);
      end
      send_grid();
      rand_items = rand_items + n;
    end

    // drain and let the block settle
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (paths.errors == 0 && paths.routes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### grid_bfs_shortest_path_unit.f
src/gbsp_pkg.sv
src/grid_bfs_shortest_path_unit.sv
tb/grid_bfs_shortest_path_unit_tb.sv
